// File: rtl/core/sorted_set_insert_remove_assert.svh
// ----------------------------------------------------------------------------
// Sorted set assertion macros
// Shorthand for the concurrent checks used in the sorted set RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_INSERT_REMOVE_ASSERT_SVH
`define SORTED_SET_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSIR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted set check failed");

// Next-cycle implication, disabled during reset.
`define SSIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted set check failed");

`endif

// File: rtl/core/ssir_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set package
// Shared constants, codes and types of the sorted set block.
// ----------------------------------------------------------------------------
package ssir_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 32;

  // Fixed widths of the channel fields.
  localparam int IN_KEY_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rem_en;
  } cell_ctl_t;

endpackage

// File: rtl/core/ssir_if.sv
// ----------------------------------------------------------------------------
// Sorted set channel interfaces
// Request channel (kind, key) and result channel (status, entry_count).
// ----------------------------------------------------------------------------
interface ssir_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ssir_pkg::IN_KEY_W-1:0] key;

  modport source(output valid, kind, key, input ready);
  modport sink(input valid, kind, key, output ready);
endinterface

interface ssir_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssir_pkg::STATUS_W-1:0] status;
  logic [ssir_pkg::COUNT_W-1:0]  entry_count;

  modport source(output valid, status, entry_count, input ready);
  modport sink(input valid, status, entry_count, output ready);
endinterface

// File: rtl/core/ssir_cell.sv
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one key, compares it with the request key and shifts toward either
// neighbor on insert or remove.
// ----------------------------------------------------------------------------
module ssir_cell #(
  parameter int KEY_BITS = ssir_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ssir_pkg::cell_ctl_t ctl,
  input  logic                occ,
  input  logic [KEY_BITS-1:0] cmp_key,
  input  logic [KEY_BITS-1:0] ins_key,
  input  logic                prev_lt,
  input  logic [KEY_BITS-1:0] prev_key,
  input  logic [KEY_BITS-1:0] next_key,
  output logic [KEY_BITS-1:0] key_r,
  output logic                lt_r,
  output logic                eq_r
);

  logic [KEY_BITS-1:0] key_nxt;

  // Cells below the insert point keep their key. The first cell at or above
  // it takes the new key, the rest take their left neighbor's key. A remove
  // pulls every cell from the matching one upward one place down.
  always_comb begin
    key_nxt = key_r;
    if (!lt_r) begin
      if (ctl.ins_en) begin
        key_nxt = prev_lt ? ins_key : prev_key;
      end else if (ctl.rem_en) begin
        key_nxt = next_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      lt_r <= occ && (key_r < cmp_key);
      eq_r <= occ && (key_r == cmp_key);
    end
  end

endmodule

// File: rtl/core/sorted_set_insert_remove.sv
// ----------------------------------------------------------------------------
// Sorted set with insert and remove
// Keeps up to CAPACITY distinct keys in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// For each request word, every cell's comparison of its key with the request
// key is registered when the word is accepted; then the chain shifts one
// place in one step and the result word is loaded into the output register.
// That commit waits while an earlier result word has not been taken, and a
// new request word is accepted as soon as the commit is done, not before.
// The chain needs no clearing after reset: only cells below the entry count
// are ever looked at.
`include "sorted_set_insert_remove_assert.svh"

module sorted_set_insert_remove #(
  parameter int CAPACITY = ssir_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = ssir_pkg::KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ssir_in_if.sink   in_chan,
  ssir_out_if.source out_chan
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_BITS-1:0]   req_key;
  logic [KEY_BITS-1:0]   key_r;
  logic                  kind_r;
  logic                  busy_r;
  logic                  busy_nxt;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  ssir_pkg::status_t     status_r;
  ssir_pkg::status_t     status_nxt;
  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [CAPACITY-1:0]   lt_vec;
  logic [CAPACITY-1:0]   eq_vec;
  logic                  in_acc;
  logic                  commit;
  logic                  hit;
  logic                  full;
  logic                  do_ins;
  logic                  do_rem;
  ssir_pkg::cell_ctl_t   ctl;
  logic [ssir_pkg::COUNT_W+CNT_W-1:0] count_ext;

  // Keys narrower than the port are truncated, wider ones zero-extended.
  assign req_key = KEY_BITS'(in_chan.key);

  assign in_chan.ready = !busy_r;
  assign in_acc        = in_chan.valid && !busy_r;
  assign commit        = busy_r && (!out_valid_r || out_chan.ready);

  assign hit    = |eq_vec;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign do_ins = commit && (kind_r == ssir_pkg::KIND_INSERT) && !hit && !full;
  assign do_rem = commit && (kind_r == ssir_pkg::KIND_REMOVE) && hit;

  assign ctl.cmp_en = in_acc;
  assign ctl.ins_en = do_ins;
  assign ctl.rem_en = do_rem;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                occ;
    logic                prev_lt;
    logic [KEY_BITS-1:0] prev_key;
    logic [KEY_BITS-1:0] next_key;

    assign occ = (IDX < count_r);

    if (i == 0) begin : g_head
      // Everything before the first cell counts as smaller than the key.
      assign prev_lt  = 1'b1;
      assign prev_key = cell_key[i];
    end else begin : g_body
      assign prev_lt  = lt_vec[i-1];
      assign prev_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key = cell_key[i];
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    ssir_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .occ     (occ),
      .cmp_key (req_key),
      .ins_key (key_r),
      .prev_lt (prev_lt),
      .prev_key(prev_key),
      .next_key(next_key),
      .key_r   (cell_key[i]),
      .lt_r    (lt_vec[i]),
      .eq_r    (eq_vec[i])
    );
  end

  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (kind_r == ssir_pkg::KIND_INSERT) begin
        priority if (hit) begin
          status_nxt = ssir_pkg::STATUS_MISS;
        end else if (full) begin
          status_nxt = ssir_pkg::STATUS_FULL;
        end else begin
          status_nxt = ssir_pkg::STATUS_DONE;
          count_nxt  = count_r + CNT_W'(1);
        end
      end else begin
        if (hit) begin
          status_nxt = ssir_pkg::STATUS_DONE;
          count_nxt  = count_r - CNT_W'(1);
        end else begin
          status_nxt = ssir_pkg::STATUS_MISS;
        end
      end
    end
    if (in_acc) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ssir_pkg::STATUS_DONE;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r  <= req_key;
      kind_r <= in_chan.kind;
    end
  end

  // The reported count is the low bits of the held count.
  assign count_ext = {{ssir_pkg::COUNT_W{1'b0}}, count_r};

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.entry_count = count_ext[ssir_pkg::COUNT_W-1:0];

  `SSIR_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SSIR_ASSERT_IMPL(a_keys_sorted, busy_r, (lt_vec & (lt_vec + CAPACITY'(1))) == '0)
  `SSIR_ASSERT_IMPL(a_keys_distinct, busy_r, $onehot0(eq_vec))
  `SSIR_ASSERT_NEXT(a_insert_count, do_ins, count_r == $past(count_r) + CNT_W'(1))
  `SSIR_ASSERT_NEXT(a_remove_count, do_rem, count_r == $past(count_r) - CNT_W'(1))

endmodule

// File: dv/sorted_set_insert_remove_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set checker
// Watches both channels and keeps its own copy of the key set. Every request
// word accepted on the input channel is applied to that copy, and the status
// and entry count it yields are queued. Every result word taken from the
// output channel is compared field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module sorted_set_insert_remove_check (
  input  logic clk,
  input  logic rst_n,
  ssir_in_if   in_mon,
  ssir_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  localparam int SET_DEPTH = ssir_pkg::CAPACITY_DEF;
  localparam logic [ssir_pkg::IN_KEY_W-1:0] KEY_MASK =
    (ssir_pkg::KEY_BITS_DEF >= ssir_pkg::IN_KEY_W) ? '1 :
    ssir_pkg::IN_KEY_W'((64'd1 << ssir_pkg::KEY_BITS_DEF) - 64'd1);

  typedef struct packed {
    ssir_pkg::status_t                  status;
    logic [ssir_pkg::COUNT_W-1:0]       entry_count;
  } set_result_t;

  logic [ssir_pkg::IN_KEY_W-1:0] held_keys [SET_DEPTH];
  int                            held_n;
  set_result_t                   due_results [$];
  int                            err_cnt;

  // Applies one insert or remove to the held keys and returns its result.
  function automatic set_result_t apply_set_op(
    input logic                          op,
    input logic [ssir_pkg::IN_KEY_W-1:0] key_in
  );
    logic [ssir_pkg::IN_KEY_W-1:0] k;
    int                            pos;
    logic                          hit;
    set_result_t                   res;
    k   = key_in & KEY_MASK;
    pos = 0;
    hit = 1'b0;
    // Stop at the first held key that is not below the request key.
    while (pos < held_n && !hit && k >= held_keys[pos]) begin
      if (held_keys[pos] == k) hit = 1'b1;
      else pos++;
    end
    if (op == ssir_pkg::KIND_INSERT) begin
      if (hit) begin
        res.status = ssir_pkg::STATUS_MISS;
      end else if (held_n >= SET_DEPTH) begin
        res.status = ssir_pkg::STATUS_FULL;
      end else begin
        for (int i = held_n; i > pos; i--) held_keys[i] = held_keys[i-1];
        held_keys[pos] = k;
        held_n++;
        res.status = ssir_pkg::STATUS_DONE;
      end
    end else begin
      if (!hit) begin
        res.status = ssir_pkg::STATUS_MISS;
      end else begin
        for (int i = pos; i + 1 < held_n; i++) held_keys[i] = held_keys[i+1];
        held_n--;
        res.status = ssir_pkg::STATUS_DONE;
      end
    end
    res.entry_count = ssir_pkg::COUNT_W'(held_n);
    return res;
  endfunction

  always @(posedge clk) begin
    set_result_t want;
    if (!rst_n) begin
      due_results.delete();
      held_n = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          $error("result word with no request outstanding: status %0d, entry_count %0d",
                 out_mon.status, out_mon.entry_count);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          if (out_mon.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_mon.status);
            err_cnt++;
          end
          if (out_mon.entry_count !== want.entry_count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   want.entry_count, out_mon.entry_count);
            err_cnt++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        due_results.push_back(apply_set_op(in_mon.kind, in_mon.key));
      end
    end
    fail_count <= err_cnt;
    pending    <= due_results.size();
  end

endmodule

// File: dv/sorted_set_insert_remove_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set testbench
// Drives insert and remove words into the sorted set, first a directed run
// over empty, full and duplicate cases, then random words drawn mostly from
// a small key pool so that hits, misses and a full store are common. Both
// channels idle at random; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module sorted_set_insert_remove_tb;

  localparam int POOL_N      = 20;
  localparam int SEGMENTS    = 8;
  localparam int SEG_WORDS   = 190;
  localparam int HOLD_CYCLES = 300;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;
  logic rx_hold = 1'b0;
  int   tx_idle_pct = 34;
  int   rx_idle_pct = 52;
  int   fail_count;
  int   pending;
  event rx_hold_ev;

  logic [ssir_pkg::IN_KEY_W-1:0] key_pool [POOL_N];

  ssir_in_if  in_chan ();
  ssir_out_if out_chan ();

  sorted_set_insert_remove u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sorted_set_insert_remove_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_chan.ready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // Long receiver stall, counted here so the sender keeps offering words.
  initial forever begin
    @(rx_hold_ev);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL sorted_set_insert_remove");
    $finish;
  end

  task automatic send_word(input logic op, input logic [ssir_pkg::IN_KEY_W-1:0] key);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind  <= op;
    in_chan.key   <= key;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_N; i++) begin
      case ($urandom_range(15))
        0:       key_pool[i] = '0;
        1:       key_pool[i] = '1;
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  task automatic random_words(input int count);
    int                            insert_pct;
    logic                          op;
    logic [ssir_pkg::IN_KEY_W-1:0] key;
    insert_pct = $urandom_range(35, 75);
    for (int n = 0; n < count; n++) begin
      // The insert bias drifts so the set both fills up and drains.
      if (n % 40 == 0) insert_pct = $urandom_range(30, 80);
      op  = ($urandom_range(99) < insert_pct) ? ssir_pkg::KIND_INSERT
                                              : ssir_pkg::KIND_REMOVE;
      key = ($urandom_range(3) == 0) ? ssir_pkg::IN_KEY_W'($urandom)
                                     : key_pool[$urandom_range(POOL_N - 1)];
      send_word(op, key);
    end
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.kind  = ssir_pkg::KIND_INSERT;
    in_chan.key   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: empty store, extremes, duplicates, full store.
    send_word(ssir_pkg::KIND_REMOVE, 32'h0000_0000);
    send_word(ssir_pkg::KIND_INSERT, 32'h0000_0000);
    send_word(ssir_pkg::KIND_INSERT, 32'hFFFF_FFFF);
    send_word(ssir_pkg::KIND_INSERT, 32'h0000_0000);
    send_word(ssir_pkg::KIND_INSERT, 32'h8000_0000);
    send_word(ssir_pkg::KIND_INSERT, 32'h7FFF_FFFF);
    send_word(ssir_pkg::KIND_REMOVE, 32'h7FFF_FFFF);
    send_word(ssir_pkg::KIND_REMOVE, 32'h0001_2345);
    for (int i = 0; i < 13; i++) begin
      send_word(ssir_pkg::KIND_INSERT,
                ssir_pkg::IN_KEY_W'((i * 7) % 13 + 1) * 32'h1111_1111);
    end
    send_word(ssir_pkg::KIND_INSERT, 32'h4000_0000);
    send_word(ssir_pkg::KIND_INSERT, 32'h8000_0000);
    send_word(ssir_pkg::KIND_REMOVE, 32'hFFFF_FFFF);
    send_word(ssir_pkg::KIND_REMOVE, 32'h0000_0000);
    drain_results();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 0) begin
        tx_idle_pct <= 34;
        rx_idle_pct <= 52;
      end else if (seg == 3) begin
        drain_results();
        tx_idle_pct <= 52;
        rx_idle_pct <= 34;
      end else if (seg == 6) begin
        drain_results();
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        @(posedge clk);
        -> rx_hold_ev;
      end
      refill_pool();
      random_words(SEG_WORDS);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS sorted_set_insert_remove");
    end else begin
      $display("FAIL sorted_set_insert_remove");
    end
    $finish;
  end

endmodule
